// File: hdl/wcg_pkg.sv
// Package for the window coefficient generator.
// Holds the register and window codes and the fixed-point constants of the cosine series.
// It depends on nothing else.
package wcg_pkg;

	localparam int unsigned DEF_MAX_LENGTH     = 4096;
	localparam int unsigned DEF_COEF_FRAC_BITS = 16;

	localparam logic [31:0] PI_Q30  = 32'd3373259426;
	localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

	localparam int unsigned SERIES_TERMS = 9;
	localparam int unsigned COS_STAGES   = 3 * SERIES_TERMS + 3;

	// Divisors (2k-1)*2k of the series, with reciprocals rounded down.
	localparam int unsigned SERIES_DIV [SERIES_TERMS] =
		'{2, 12, 30, 56, 90, 132, 182, 240, 306};
	localparam int unsigned SERIES_SHIFT [SERIES_TERMS] =
		'{32, 35, 36, 37, 38, 39, 39, 39, 40};
	localparam logic [31:0] SERIES_MUL [SERIES_TERMS] = '{
		32'((64'd1 << 32) / 64'd2),
		32'((64'd1 << 35) / 64'd12),
		32'((64'd1 << 36) / 64'd30),
		32'((64'd1 << 37) / 64'd56),
		32'((64'd1 << 38) / 64'd90),
		32'((64'd1 << 39) / 64'd132),
		32'((64'd1 << 39) / 64'd182),
		32'((64'd1 << 39) / 64'd240),
		32'((64'd1 << 40) / 64'd306)
	};

	localparam int unsigned PCT_DIV   = 100;
	localparam int unsigned PCT_SHIFT = 38;
	localparam logic [31:0] PCT_MUL   = 32'((64'd1 << 38) / 64'd100);

	typedef enum logic {
		REG_WINDOW_TYPE   = 1'b0,
		REG_WINDOW_LENGTH = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		WIN_HANN     = 2'd0,
		WIN_HAMMING  = 2'd1,
		WIN_BLACKMAN = 2'd2
	} win_type_t;

endpackage

// File: hdl/wcg_cos.sv
// Pipelined cosine of a 32-bit turn fraction, result in signed Q30.
// A nine-term series, three stages per term, with stage enables from the caller.
// Depends on wcg_pkg.
module wcg_cos
	import wcg_pkg::*;
(
	input  logic                  clk,
	input  logic [COS_STAGES-1:0] en,
	input  logic [31:0]           phase,
	output logic signed [31:0]    cos_val
);

	typedef struct packed {
		logic [31:0]        x2;
		logic signed [33:0] sum;
		logic [1:0]         quad;
		logic [31:0]        p;
		logic [31:0]        q0;
		logic [30:0]        term;
	} ser_t;

	logic [30:0] x_s1;
	logic [1:0]  quad_s1;
	ser_t        ser_s [0:3*SERIES_TERMS];

	logic [30:0] r_fold;
	logic [33:0] sum_fin;
	logic signed [33:0] sum_cl;

	function automatic ser_t ser_mul(ser_t s);
		logic [62:0] prod;
		ser_t        o;
		o      = s;
		prod   = 63'(s.term) * 63'(s.x2);
		o.p    = prod[61:30];
		return o;
	endfunction

	function automatic ser_t ser_rcp(ser_t s, int k);
		logic [63:0] prod;
		ser_t        o;
		o    = s;
		prod = 64'(s.p) * 64'(SERIES_MUL[k]);
		o.q0 = 32'(prod >> SERIES_SHIFT[k]);
		return o;
	endfunction

	function automatic ser_t ser_fix(ser_t s, int k);
		logic [31:0] r;
		logic [30:0] t;
		ser_t        o;
		o = s;
		r = s.p - 32'(s.q0 * 32'(SERIES_DIV[k]));
		t = 31'(s.q0) + 31'(r >= 32'(SERIES_DIV[k]));
		o.term = t;
		if (k[0] == 1'b0) begin
			o.sum = s.sum - $signed({3'b0, t});
		end else begin
			o.sum = s.sum + $signed({3'b0, t});
		end
		return o;
	endfunction

	always_comb begin
		r_fold = {1'b0, phase[29:0]};
		if (phase[30]) begin
			r_fold = ONE_Q30 - r_fold;
		end
	end

	always_comb begin
		sum_cl = ser_s[3*SERIES_TERMS].sum;
		if (sum_cl < 34'sd0) begin
			sum_cl = 34'sd0;
		end else if (sum_cl > $signed({3'b0, ONE_Q30})) begin
			sum_cl = $signed({3'b0, ONE_Q30});
		end
		if (ser_s[3*SERIES_TERMS].quad == 2'd1 || ser_s[3*SERIES_TERMS].quad == 2'd2) begin
			sum_fin = -sum_cl;
		end else begin
			sum_fin = sum_cl;
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			x_s1    <= 31'((64'(r_fold) * 64'(PI_Q30)) >> 31);
			quad_s1 <= phase[31:30];
		end
		if (en[1]) begin
			ser_s[0].x2   <= 32'((62'(x_s1) * 62'(x_s1)) >> 30);
			ser_s[0].sum  <= $signed({3'b0, ONE_Q30});
			ser_s[0].quad <= quad_s1;
			ser_s[0].p    <= '0;
			ser_s[0].q0   <= '0;
			ser_s[0].term <= ONE_Q30;
		end
		for (int k = 0; k < SERIES_TERMS; k++) begin
			if (en[2 + 3*k]) begin
				ser_s[3*k + 1] <= ser_mul(ser_s[3*k]);
			end
			if (en[3 + 3*k]) begin
				ser_s[3*k + 2] <= ser_rcp(ser_s[3*k + 1], k);
			end
			if (en[4 + 3*k]) begin
				ser_s[3*k + 3] <= ser_fix(ser_s[3*k + 2], k);
			end
		end
		if (en[COS_STAGES-1]) begin
			cos_val <= $signed(sum_fin[31:0]);
		end
	end

endmodule

// File: hdl/window_coefficient_generator_core.sv
// Window coefficient generator: Hann, Hamming or Blackman coefficient per sample index.
// Top level; depends on wcg_pkg and wcg_cos.
// Uses two registers written over the configuration channel.
//
// One index is taken every cycle while sample_stall is low, and its coefficient comes out in
// unsigned Q1.COEF_FRAC_BITS after passing 42 register stages. Most of these stages belong to
// the restoring divider for the phase (eight stages of four quotient bits) and to the cosine
// series (nine terms of three stages each); each stage carries its own valid bit, so bubbles
// are squeezed out when the output stalls.
// Write the registers only with no transfer in flight.
module window_coefficient_generator_core
	import wcg_pkg::*;
#(
	parameter int unsigned MAX_LENGTH     = DEF_MAX_LENGTH,
	parameter int unsigned COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic                      cfg_index,
	input  logic [12:0]               cfg_data,
	input  logic                      sample_valid,
	output logic                      sample_stall,
	input  logic [11:0]               sample_index,
	output logic                      coef_valid,
	input  logic                      coef_stall,
	output logic [COEF_FRAC_BITS:0]   coefficient,
	output logic                      index_error
);

	localparam int unsigned DIV_BITS   = 4;
	localparam int unsigned DIV_STAGES = 32 / DIV_BITS;
	localparam int unsigned ST_DIV0    = 2;
	localparam int unsigned ST_COS0    = ST_DIV0 + DIV_STAGES;
	localparam int unsigned ST_V       = ST_COS0 + COS_STAGES;
	localparam int unsigned ST_RCP     = ST_V + 1;
	localparam int unsigned NS         = ST_RCP + 1;
	localparam int unsigned VSHIFT     = 30 - COEF_FRAC_BITS;
	localparam logic [31:0] ONE_W      = 32'd1 << COEF_FRAC_BITS;

	typedef struct packed {
		logic err;
		logic one;
	} flags_t;

	typedef struct packed {
		logic [12:0]         rem;
		logic [DIV_BITS-1:0] bits;
	} div_res_t;

	logic [1:0]  wtype_q;
	logic [12:0] wlen_q;
	logic [12:0] n_eff;
	logic [12:0] d;
	logic [12:0] idx_w;

	logic [NS:1]   vld_q;
	logic [NS:1]   vld_in;
	logic [NS+1:1] rdy;

	flags_t      flg_s [1:NS];
	logic [12:0] div_rem_s [0:DIV_STAGES];
	logic [31:0] div_quo_s [0:DIV_STAGES];

	logic        extra;
	logic [31:0] u1;
	logic [31:0] u2;
	logic signed [31:0] c1;
	logic signed [31:0] c2;

	logic signed [39:0] wa;
	logic signed [39:0] wb;
	logic signed [39:0] wc;
	logic signed [39:0] v;

	logic [31:0] num_s40;
	logic        pos_s40;
	logic [31:0] num_s41;
	logic [31:0] quo_s41;
	logic        pos_s41;
	logic [31:0] rem_o;
	logic [31:0] coef_o;
	logic [COEF_FRAC_BITS:0] coef_s42;
	logic        err_s42;

	function automatic div_res_t div_step(logic [12:0] rem, logic [12:0] dv);
		logic [13:0] sh;
		div_res_t    o;
		o.rem  = rem;
		o.bits = '0;
		for (int b = 0; b < DIV_BITS; b++) begin
			sh = {o.rem, 1'b0};
			if (sh >= {1'b0, dv}) begin
				sh = sh - {1'b0, dv};
				o.bits[DIV_BITS-1-b] = 1'b1;
			end
			o.rem = sh[12:0];
		end
		return o;
	endfunction

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wtype_q <= WIN_HANN;
			wlen_q  <= 13'd256;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_WINDOW_TYPE:   wtype_q <= cfg_data[1:0];
				REG_WINDOW_LENGTH: wlen_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign n_eff = ({4'b0, wlen_q} > 17'(MAX_LENGTH)) ? 13'(MAX_LENGTH) : wlen_q;
	assign d     = n_eff - 13'd1;
	assign idx_w = {1'b0, sample_index};

	assign rdy[NS+1] = ~coef_stall;
	for (genvar k = 1; k <= NS; k++) begin : g_rdy
		assign rdy[k] = ~vld_q[k] | rdy[k+1];
	end
	assign vld_in       = {vld_q[NS-1:1], sample_valid};
	assign sample_stall = ~rdy[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= (vld_q & ~rdy[NS:1]) | (vld_in & rdy[NS:1]);
		end
	end

	assign extra = {div_rem_s[DIV_STAGES], 1'b0} >= {1'b0, d};
	assign u1    = div_quo_s[DIV_STAGES];
	assign u2    = {div_quo_s[DIV_STAGES][30:0], extra};

	wcg_cos u_cos1 (
		.clk     (clk),
		.en      (rdy[ST_COS0 + COS_STAGES - 1 : ST_COS0]),
		.phase   (u1),
		.cos_val (c1)
	);

	wcg_cos u_cos2 (
		.clk     (clk),
		.en      (rdy[ST_COS0 + COS_STAGES - 1 : ST_COS0]),
		.phase   (u2),
		.cos_val (c2)
	);

	always_comb begin
		case (win_type_t'(wtype_q))
			WIN_HANN: begin
				wa = 40'sd50; wb = 40'sd50; wc = 40'sd0;
			end
			WIN_HAMMING: begin
				wa = 40'sd54; wb = 40'sd46; wc = 40'sd0;
			end
			WIN_BLACKMAN: begin
				wa = 40'sd42; wb = 40'sd50; wc = 40'sd8;
			end
			default: begin
				wa = 40'sd0; wb = 40'sd0; wc = 40'sd0;
			end
		endcase
		v = (wa <<< 30) - wb * 40'(c1) + wc * 40'(c2);
	end

	always_comb begin
		rem_o  = num_s41 - 32'(quo_s41 * 32'(PCT_DIV));
		coef_o = quo_s41 + 32'(rem_o >= 32'(PCT_DIV));
		if (coef_o > ONE_W) begin
			coef_o = ONE_W;
		end
		if (flg_s[NS-1].err) begin
			coef_o = '0;
		end else if (flg_s[NS-1].one) begin
			coef_o = ONE_W;
		end else if (!pos_s41) begin
			coef_o = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[1]) begin
			flg_s[1].err <= idx_w >= n_eff;
			flg_s[1].one <= n_eff == 13'd1;
			div_rem_s[0] <= (idx_w >= d) ? idx_w - d : idx_w;
			div_quo_s[0] <= '0;
		end
		for (int k = 2; k <= NS; k++) begin
			if (rdy[k]) begin
				flg_s[k] <= flg_s[k-1];
			end
		end
		for (int g = 0; g < DIV_STAGES; g++) begin
			if (rdy[ST_DIV0 + g]) begin
				div_rem_s[g+1] <= div_step(div_rem_s[g], d).rem;
				div_quo_s[g+1] <= {div_quo_s[g][31-DIV_BITS:0], div_step(div_rem_s[g], d).bits};
			end
		end
		if (rdy[ST_V]) begin
			pos_s40 <= v > 40'sd0;
			num_s40 <= 32'(v >>> VSHIFT) + 32'd50;
		end
		if (rdy[ST_RCP]) begin
			pos_s41 <= pos_s40;
			num_s41 <= num_s40;
			quo_s41 <= 32'((64'(num_s40) * 64'(PCT_MUL)) >> PCT_SHIFT);
		end
		if (rdy[NS]) begin
			coef_s42 <= (COEF_FRAC_BITS+1)'(coef_o);
			err_s42  <= flg_s[NS-1].err;
		end
	end

	assign coef_valid  = vld_q[NS];
	assign coefficient = coef_s42;
	assign index_error = err_s42;

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		coef_valid && index_error |-> coefficient == '0)
		else $error("index error transfer carries a nonzero coefficient");

	a_coef_max: assert property (@(posedge clk) disable iff (!arst_n)
		coef_valid |-> {{(31-COEF_FRAC_BITS){1'b0}}, coefficient} <= ONE_W)
		else $error("coefficient above one");

	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!coef_stall |-> !sample_stall)
		else $error("input stalled while output is free");

endmodule
